// ===== hdl/tcw_pkg.sv =====
// Shared types, constants and helpers for the text console writer.
// Used by tcw_ctrl, tcw_dp and text_console_writer_top. No dependencies.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;

	localparam logic [COL_W-1:0] COL_N = COL_W'(COLUMNS);
	localparam logic [ROW_W-1:0] ROW_N = ROW_W'(ROWS);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [IDX_W-1:0] COLS_I = IDX_W'(COLUMNS);
	localparam logic [IDX_W-1:0] CELL_LAST = IDX_W'(CELL_COUNT - 1);
	localparam logic [IDX_W-1:0] COPY_LAST = IDX_W'(COPY_COUNT - 1);
	localparam logic [IDX_W-1:0] CELL_N = IDX_W'(CELL_COUNT);

	localparam logic [1:0] FUNC_PUT   = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] RESET_ATTR   = 8'h0F;

	typedef struct packed {
		logic [1:0]       func;
		logic [7:0]       char_code;
		logic [IDX_W-1:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture accepted item
		logic exec;       // decode and run the item
		logic fill;       // write blank cell at sweep counter
		logic fill_init;  // blank with reset attribute
		logic copy;       // read one row below for scroll
		logic cnt_inc;
		logic putc;       // write char at cursor after scroll
		logic load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_clear;
		logic scroll_need;
		logic cnt_last_copy;
		logic cnt_last_cell;
	} dp_sts_t;

	function automatic logic [IDX_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		cell_addr = IDX_W'(IDX_W'(row) * COLS_I) + IDX_W'(col);
	endfunction

endpackage

// ===== hdl/text_console_writer_top.sv =====
// Channel    Dir  Handshake              Payload
// cmd        in   cmd_valid/cmd_ready    cmd_t  {func, char_code, cell_index}
// rsp        out  rsp_valid/rsp_ready    rsp_t  {cell_value, cursor_col, cursor_row}
// apb        in   psel/penable, pready=1 text_attribute at byte address 0
//
// Plain put, return, newline, backspace, read and unused codes: idle, then decode.
// Scroll (ordinary byte with a row pending): copy sweep, drain, blank sweep, then the char,
// with one-cell-per-cycle copy and blank sweeps over the screen memory.
// Clear screen: a blank sweep over all COLUMNS*ROWS cells. After reset a clearing pass
// over all COLUMNS*ROWS cells (2000) runs with cmd_ready low. A stalled rsp still lets one
// more item run; the item after that waits in idle until the result register frees.
// Depends on tcw_pkg, tcw_ctrl and tcw_dp.
module text_console_writer_top import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dp_cmd_t    ctl;
	dp_sts_t    sts;
	logic [7:0] attr_q;
	logic       attr_sel;

	assign pready   = 1'b1;
	assign attr_sel = paddr[2] == 1'b0;
	assign prdata   = attr_sel ? {24'd0, attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (psel && penable && pwrite && pready && attr_sel) begin
			attr_q <= pwdata[7:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	tcw_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cmd_in  (cmd),
		.attr    (attr_q),
		.sts     (sts),
		.rsp_out (rsp)
	);

endmodule

// ===== hdl/tcw_dp.sv =====
// Datapath: item latch, cursor, sweep counter, screen memory, result register.
// Depends on tcw_pkg; driven by tcw_ctrl.
module tcw_dp import tcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    ctl,
	input  cmd_t       cmd_in,
	input  logic [7:0] attr,
	output dp_sts_t    sts,
	output rsp_t       rsp_out
);

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;
	cmd_t              item_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              rd_hit_q;
	logic              copy_vld_s1;
	logic [IDX_W-1:0]  waddr_s1;
	rsp_t              rsp_q;

	logic              is_nl, is_cr, is_bs, is_put, wrap;
	logic [COL_W-1:0]  wrap_col;
	logic [ROW_W-1:0]  wrap_row;
	logic              we, re;
	logic [IDX_W-1:0]  waddr, raddr;
	logic [CELL_W-1:0] wdata;
	logic              rd_ok;

	assign is_put   = item_q.func == FUNC_PUT;
	assign is_nl    = item_q.char_code == CH_NEWLINE;
	assign is_cr    = item_q.char_code == CH_RETURN;
	assign is_bs    = item_q.char_code == CH_BACKSPACE;
	assign wrap     = col_q >= COL_N;
	assign wrap_col = wrap ? '0 : col_q;
	assign wrap_row = (wrap && row_q < ROW_N) ? row_q + ROW_W'(1) : row_q;
	assign rd_ok    = item_q.cell_index < CELL_N;

	assign sts.is_clear      = item_q.func == FUNC_CLEAR;
	assign sts.scroll_need   = is_put && !is_nl && !is_cr && !is_bs && wrap_row >= ROW_N;
	assign sts.cnt_last_copy = cnt_q == COPY_LAST;
	assign sts.cnt_last_cell = cnt_q == CELL_LAST;

	// one write port: copy pipeline, sweep fill, char after scroll, direct put
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = {attr, CH_SPACE};
		if (copy_vld_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = rdata_q;
		end else if (ctl.fill) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = {(ctl.fill_init ? RESET_ATTR : attr), CH_SPACE};
		end else if (ctl.putc) begin
			we    = 1'b1;
			waddr = cell_addr(row_q, col_q);
			wdata = {attr, item_q.char_code};
		end else if (ctl.exec && is_put) begin
			if (is_bs) begin
				we    = col_q != '0 && row_q < ROW_N;
				waddr = cell_addr(row_q, col_q - COL_W'(1));
				wdata = {attr, CH_SPACE};
			end else if (!is_nl && !is_cr && !sts.scroll_need) begin
				we    = 1'b1;
				waddr = cell_addr(wrap_row, wrap_col);
				wdata = {attr, item_q.char_code};
			end
		end
	end

	assign re    = ctl.copy || (ctl.exec && item_q.func == FUNC_READ && rd_ok);
	assign raddr = ctl.copy ? cnt_q + COLS_I : item_q.cell_index;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			item_q <= cmd_in;
		end
		if (ctl.copy) begin
			waddr_s1 <= cnt_q;
		end
		if (ctl.load_out) begin
			rsp_q.cell_value <= rd_hit_q ? rdata_q : '0;
			rsp_q.cursor_col <= col_q;
			rsp_q.cursor_row <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			rd_hit_q    <= 1'b0;
			copy_vld_s1 <= 1'b0;
		end else begin
			copy_vld_s1 <= ctl.copy;
			if (ctl.exec) begin
				cnt_q    <= '0;
				rd_hit_q <= item_q.func == FUNC_READ && rd_ok;
			end else if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (ctl.putc) begin
				col_q <= col_q + COL_W'(1);
			end else if (ctl.exec) begin
				if (sts.is_clear) begin
					col_q <= '0;
					row_q <= '0;
				end else if (is_put) begin
					if (is_nl) begin
						col_q <= '0;
						row_q <= (row_q < ROW_N) ? row_q + ROW_W'(1) : row_q;
					end else if (is_cr) begin
						col_q <= '0;
					end else if (is_bs) begin
						if (col_q != '0) begin
							col_q <= col_q - COL_W'(1);
						end
					end else if (sts.scroll_need) begin
						// char goes in after the scroll, on the last row
						col_q <= wrap_col;
						row_q <= ROW_LAST;
					end else begin
						col_q <= wrap_col + COL_W'(1);
						row_q <= wrap_row;
					end
				end
			end
		end
	end

	assign rsp_out = rsp_q;

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> !ctl.fill && !ctl.putc && !ctl.exec)
		else $error("write port claimed twice during scroll copy");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_N && row_q <= ROW_N)
		else $error("cursor out of range");
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.copy |=> row_q == ROW_LAST && copy_vld_s1)
		else $error("scroll copy without cursor parked on last row");

endmodule

// ===== hdl/tcw_ctrl.sv =====
// Controller state machine: handshakes, item sequencing, memory sweeps.
// Depends on tcw_pkg; drives tcw_dp through dp_cmd_t.
module tcw_ctrl import tcw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  dp_sts_t sts,
	output dp_cmd_t ctl
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_SCROLL = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_BLANK  = 3'd5;
	localparam logic [2:0] S_PUTC   = 3'd6;
	localparam logic [2:0] S_CLEAR  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       pend_q, pend_set;
	logic       out_vld_q;
	logic       out_free, accept;

	assign out_free  = !out_vld_q || rsp_ready;
	assign cmd_ready = state_q == S_IDLE && (!pend_q || out_free);
	assign accept    = cmd_valid && cmd_ready;
	assign rsp_valid = out_vld_q;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		pend_set = 1'b0;
		case (state_q)
			S_INIT: begin
				ctl.fill      = 1'b1;
				ctl.fill_init = 1'b1;
				ctl.cnt_inc   = 1'b1;
				if (sts.cnt_last_cell) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				ctl.load_out = pend_q && out_free;
				ctl.latch    = accept;
				if (accept) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.exec = 1'b1;
				if (sts.is_clear) begin
					state_d = S_CLEAR;
				end else if (sts.scroll_need) begin
					state_d = S_SCROLL;
				end else begin
					state_d  = S_IDLE;
					pend_set = 1'b1;
				end
			end
			S_SCROLL: begin
				ctl.copy    = 1'b1;
				ctl.cnt_inc = 1'b1;
				if (sts.cnt_last_copy) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last copied cell is written this cycle
				state_d = S_BLANK;
			end
			S_BLANK: begin
				ctl.fill    = 1'b1;
				ctl.cnt_inc = 1'b1;
				if (sts.cnt_last_cell) begin
					state_d = S_PUTC;
				end
			end
			S_PUTC: begin
				ctl.putc = 1'b1;
				state_d  = S_IDLE;
				pend_set = 1'b1;
			end
			S_CLEAR: begin
				ctl.fill    = 1'b1;
				ctl.cnt_inc = 1'b1;
				if (sts.cnt_last_cell) begin
					state_d  = S_IDLE;
					pend_set = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pend_set) begin
				pend_q <= 1'b1;
			end else if (ctl.load_out) begin
				pend_q <= 1'b0;
			end
			if (ctl.load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q == S_IDLE)
		else $error("result pending outside idle");
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_INIT |=> state_q != S_INIT)
		else $error("clearing pass re-entered");
	a_no_accept_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !pend_q || out_vld_q)
		else $error("earlier result lost on accept");

endmodule
